// ===== design/gasa_pkg.sv =====
// ----------------------------------------------------------------------------
// gasa_pkg: shared types and constants for the glyph atlas shelf allocator
// Atlas geometry, table layout, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package gasa_pkg;

   localparam int ATLAS_SIZE = 512;
   localparam int CODE_COUNT = 4096;
   localparam int MAX_PAGES  = 256;

   localparam int CODE_W  = $clog2(CODE_COUNT);
   localparam int CX_W    = $clog2(ATLAS_SIZE) + 1;   // cursor may sit at ATLAS_SIZE
   localparam int CY_W    = $clog2(ATLAS_SIZE);
   localparam int SUM_W   = $clog2(ATLAS_SIZE) + 3;   // headroom for cursor + width + pad
   localparam int PAGES_W = $clog2(MAX_PAGES + 1);

   typedef enum logic [2:0] {
      STAT_HIT      = 3'd0,
      STAT_PLACED   = 3'd1,
      STAT_NEW_PAGE = 3'd2,
      STAT_TOO_WIDE = 3'd3,
      STAT_FULL     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CSR_CELL_HEIGHT  = 2'd0,
      CSR_CELL_PADDING = 2'd1,
      CSR_ADV_SPACING  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] page;
      logic [8:0] x;
      logic [8:0] y;
      logic [8:0] w;
   } entry_type;

   typedef struct packed {
      logic [9:0]        cell_height;
      logic [7:0]        cell_padding;
      logic signed [7:0] advance_spacing;
   } cfg_type;

   typedef struct packed {
      logic clear;    // wipe one table entry
      logic lookup;   // capture request, read table
      logic commit;   // decide, write entry, issue result
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } stat_type;

endpackage

`default_nettype wire

// ===== design/gasa_ctrl.sv =====
// ----------------------------------------------------------------------------
// gasa_ctrl: sequencer for the glyph atlas shelf allocator
// Runs the table clearing pass after reset, then lookup/commit per request.
// ----------------------------------------------------------------------------
`default_nettype none

module gasa_ctrl
   import gasa_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     start,
   input  wire stat_type stat,
   output logic          busy,
   output cmd_type       cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      busy       = 1'b1;
      cmd.clear  = 1'b0;
      cmd.lookup = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            busy       = 1'b0;
            cmd.lookup = start;
         end
         ST_LOOKUP: begin
            cmd.commit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== design/gasa_dpath.sv =====
// ----------------------------------------------------------------------------
// gasa_dpath: glyph table, shelf cursor and result registers
// Table read in the lookup cycle, placement decision and write-back the next.
// ----------------------------------------------------------------------------
`default_nettype none

module gasa_dpath
   import gasa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cmd_type     cmd,
   output stat_type         stat,
   input  wire cfg_type     cfg,
   input  wire logic [11:0] req_char_code,
   input  wire logic [7:0]  req_glyph_width,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_page,
   output logic [8:0]       rsp_origin_x,
   output logic [8:0]       rsp_origin_y,
   output logic [8:0]       rsp_cell_width,
   output logic signed [9:0] rsp_advance
);

   entry_type glyph_mem [CODE_COUNT];

   logic [CODE_W-1:0]  clr_addr_ff;
   logic [CODE_W-1:0]  idx_ff;
   logic [7:0]         gw_ff;
   entry_type          rd_ff;
   logic [CX_W-1:0]    cursor_x_ff;
   logic [CY_W-1:0]    cursor_y_ff;
   logic [PAGES_W-1:0] pages_used_ff;

   logic               valid_ff;
   status_type         status_ff;
   logic [7:0]         page_ff;
   logic [8:0]         x_ff;
   logic [8:0]         y_ff;
   logic [8:0]         w_ff;
   logic signed [9:0]  adv_ff;

   logic [8:0]       w_rnd;
   logic [SUM_W-1:0] w_pad;
   logic [SUM_W-1:0] row_end;
   logic [SUM_W-1:0] sy_row;
   logic [SUM_W-1:0] sy_bottom;
   logic             too_wide;
   logic             wrap;
   logic             new_row_page;
   logic             fresh;
   logic             full;
   logic             place;
   logic [CX_W-1:0]  sx;
   logic [SUM_W-1:0] sy;
   logic [7:0]       page_sel;
   logic [8:0]       w_sel;
   logic signed [9:0] adv_sel;
   status_type       status_sel;
   entry_type        wr_entry;

   assign stat.clear_last = (clr_addr_ff == CODE_W'(CODE_COUNT - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clear) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // placement decision, all in the commit cycle
   always_comb begin
      w_rnd        = ({1'b0, gw_ff} + 9'd1) & ~9'd1;
      w_pad        = SUM_W'(w_rnd) + SUM_W'(cfg.cell_padding);
      too_wide     = (w_pad > SUM_W'(ATLAS_SIZE))
                     || (SUM_W'(cfg.cell_height) > SUM_W'(ATLAS_SIZE));
      row_end      = SUM_W'(cursor_x_ff) + w_pad;
      wrap         = row_end > SUM_W'(ATLAS_SIZE);
      sy_row       = wrap ? SUM_W'(cursor_y_ff) + SUM_W'(cfg.cell_height)
                          : SUM_W'(cursor_y_ff);
      sy_bottom    = sy_row + SUM_W'(cfg.cell_height);
      new_row_page = sy_bottom > SUM_W'(ATLAS_SIZE);
      sx           = wrap ? '0 : cursor_x_ff;
      sy           = new_row_page ? '0 : sy_row;
      fresh        = new_row_page || (pages_used_ff == '0);
      full         = fresh && (pages_used_ff >= PAGES_W'(MAX_PAGES));
      place        = !rd_ff.valid && !too_wide && !full;
      page_sel     = fresh ? 8'(pages_used_ff) : 8'(pages_used_ff - 1'b1);

      if (rd_ff.valid) begin
         status_sel = STAT_HIT;
      end else if (too_wide) begin
         status_sel = STAT_TOO_WIDE;
      end else if (full) begin
         status_sel = STAT_FULL;
      end else if (fresh) begin
         status_sel = STAT_NEW_PAGE;
      end else begin
         status_sel = STAT_PLACED;
      end

      w_sel   = rd_ff.valid ? rd_ff.w : w_rnd;
      adv_sel = $signed({1'b0, w_sel})
                + $signed({{2{cfg.advance_spacing[7]}}, cfg.advance_spacing});

      wr_entry.valid = 1'b1;
      wr_entry.page  = page_sel;
      wr_entry.x     = 9'(sx);
      wr_entry.y     = 9'(sy);
      wr_entry.w     = w_rnd;
   end

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         glyph_mem[clr_addr_ff] <= '0;
      end else if (cmd.commit && place) begin
         glyph_mem[idx_ff] <= wr_entry;
      end
      if (cmd.lookup) begin
         rd_ff <= glyph_mem[req_char_code[CODE_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         idx_ff <= req_char_code[CODE_W-1:0];
         gw_ff  <= req_glyph_width;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff   <= '0;
         cursor_y_ff   <= '0;
         pages_used_ff <= '0;
      end else if (cmd.commit && place) begin
         cursor_x_ff <= CX_W'(SUM_W'(sx) + w_pad);
         cursor_y_ff <= CY_W'(sy);
         if (fresh) begin
            pages_used_ff <= pages_used_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.commit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_sel;
         if (rd_ff.valid) begin
            page_ff <= rd_ff.page;
            x_ff    <= rd_ff.x;
            y_ff    <= rd_ff.y;
            w_ff    <= rd_ff.w;
            adv_ff  <= adv_sel;
         end else if (place) begin
            page_ff <= page_sel;
            x_ff    <= 9'(sx);
            y_ff    <= 9'(sy);
            w_ff    <= w_rnd;
            adv_ff  <= adv_sel;
         end else begin
            page_ff <= '0;
            x_ff    <= '0;
            y_ff    <= '0;
            w_ff    <= '0;
            adv_ff  <= '0;
         end
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_page       = page_ff;
   assign rsp_origin_x   = x_ff;
   assign rsp_origin_y   = y_ff;
   assign rsp_cell_width = w_ff;
   assign rsp_advance    = adv_ff;

endmodule

`default_nettype wire

// ===== design/glyph_atlas_shelf_allocator.sv =====
// ----------------------------------------------------------------------------
// glyph_atlas_shelf_allocator: cached shelf packer for glyph atlas pages
// Looks up a char code; a miss goes on the current shelf, else a new shelf or page.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_char_code and req_glyph_width with start high; the
//   transaction is taken at a clock edge where start is high and busy is low.
//   Result: rsp_valid pulses for one cycle with status, page, origin, cell
//   width and advance. The receiver has no backpressure: sample on the pulse.
//   Sequence: the accepting edge registers the glyph table read; the commit
//   step decides, writes the entry back and registers the result. busy is
//   high in the commit step, so a new request waits until it is done.
//   Reset: synchronous, active high. Afterwards busy stays high while the
//   table is cleared one entry per cycle; configuration writes over
//   the APB port are taken at any time, including during the clear.
//   Configuration registers: 0x0 cell_height, 0x4 cell_padding,
//   0x8 advance_spacing. Write them only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module glyph_atlas_shelf_allocator
   import gasa_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [11:0] req_char_code,
   input  wire logic [7:0]  req_glyph_width,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_page,
   output logic [8:0]       rsp_origin_x,
   output logic [8:0]       rsp_origin_y,
   output logic [8:0]       rsp_cell_width,
   output logic signed [9:0] rsp_advance,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   cfg_type       cfg_ff;
   csr_index_type csr_idx;
   logic          csr_wr;
   cmd_type       cmd;
   stat_type      stat;

   assign pready  = 1'b1;
   assign csr_idx = csr_index_type'(paddr[3:2]);
   assign csr_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_height     <= 10'd16;
         cfg_ff.cell_padding    <= 8'd4;
         cfg_ff.advance_spacing <= 8'sd0;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_CELL_HEIGHT:  cfg_ff.cell_height     <= pwdata[9:0];
            CSR_CELL_PADDING: cfg_ff.cell_padding    <= pwdata[7:0];
            CSR_ADV_SPACING:  cfg_ff.advance_spacing <= $signed(pwdata[7:0]);
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_CELL_HEIGHT:  prdata = {22'd0, cfg_ff.cell_height};
         CSR_CELL_PADDING: prdata = {24'd0, cfg_ff.cell_padding};
         CSR_ADV_SPACING:  prdata = {24'd0, cfg_ff.advance_spacing};
         default:          prdata = '0;
      endcase
   end

   gasa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   gasa_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .cfg             (cfg_ff),
      .req_char_code   (req_char_code),
      .req_glyph_width (req_glyph_width),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_page        (rsp_page),
      .rsp_origin_x    (rsp_origin_x),
      .rsp_origin_y    (rsp_origin_y),
      .rsp_cell_width  (rsp_cell_width),
      .rsp_advance     (rsp_advance)
   );

`ifndef SYNTHESIS
   // every accepted transaction is followed by a result strobe after its commit step
   a_result_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result strobe missing two cycles after accept");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("controller not busy during table lookup");

   // result strobe only follows a lookup cycle
   a_strobe_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe without a preceding lookup");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STAT_TOO_WIDE || rsp_status == STAT_FULL))
      |-> (rsp_cell_width == '0 && rsp_advance == '0 && rsp_page == '0))
      else $error("error result carries nonzero placement fields");
`endif

endmodule

`default_nettype wire
